// ===== hw/rtl/sensor_running_average_alarm_defines.svh =====
// Assertion macros for the sensor running average alarm.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef SENSOR_RUNNING_AVERAGE_ALARM_DEFINES_SVH
`define SENSOR_RUNNING_AVERAGE_ALARM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sra_pkg.sv =====
// Shared widths, sensor id table, divider constants and codes for the
// sensor running average alarm. No dependencies.
package sra_pkg;

    localparam int ID_W      = 16;
    localparam int SAMPLE_W  = 16;
    localparam int TEMP_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 3;
    localparam int AVG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam int WINDOW        = 5;
    localparam int SENSOR_COUNT  = 8;
    localparam int ID_TABLE_SIZE = 8;
    localparam int MATCH_COUNT   = (SENSOR_COUNT < ID_TABLE_SIZE) ? SENSOR_COUNT
                                                                  : ID_TABLE_SIZE;

    localparam logic [ID_W-1:0] KNOWN_IDS [ID_TABLE_SIZE] = '{
        16'd15, 16'd21, 16'd37, 16'd49, 16'd112, 16'd129, 16'd132, 16'd142
    };

    localparam int SLOT_W    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int RAM_DEPTH = SENSOR_COUNT * WINDOW;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // Exact reciprocal divide of a SUM_W-bit magnitude by WINDOW.
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + WINDOW - 1) / WINDOW);

    localparam logic signed [TEMP_W-1:0] HOT_LIMIT_RST  = 16'sd6400;
    localparam logic signed [TEMP_W-1:0] COLD_LIMIT_RST = 16'sd2560;

    typedef enum logic [STATUS_W-1:0] {
        ST_FILLING  = 3'd0,
        ST_NORMAL   = 3'd1,
        ST_TOO_HOT  = 3'd2,
        ST_TOO_COLD = 3'd3,
        ST_UNKNOWN  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOT_LIMIT  = 1'd0,
        CFG_COLD_LIMIT = 1'd1
    } t_cfg_reg;

endpackage

// ===== hw/rtl/sra_if.sv =====
// Valid/ready channel interfaces: sample request, result request, config write.
// Depends on sra_pkg for field widths.
interface sra_in_if import sra_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ID_W-1:0]            reading_id;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output reading_id, output sample_value, input ready);
    modport sink   (input valid, input reading_id, input sample_value, output ready);
endinterface

interface sra_out_if import sra_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [INDEX_W-1:0]      sensor_index;
    logic signed [AVG_W-1:0] average;

    modport source (output valid, output status, output sensor_index, output average,
                    input ready);
    modport sink   (input valid, input status, input sensor_index, input average,
                    output ready);
endinterface

interface sra_cfg_if import sra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TEMP_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sra_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sra_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 40,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/sensor_running_average_alarm.sv =====
// Top level of the sensor running average alarm.
// Depends on sra_pkg, the sra_*_if interfaces, sra_ram and the assertion macros.
//
// Takes one reading per clock while the result register is free or being drained
// (sensor id, signed temperature in 1/256 degree), matches the id against eight
// fixed ids and keeps the last WINDOW samples of each sensor in a circular buffer
// in one sample RAM, with a running sum and fill count per sensor in flops. A full
// window gives the average (sum / WINDOW, toward zero, by reciprocal multiply) and
// a hot/cold flag against the hot and cold limit registers; a filling window
// reports status 0, an unknown id status 4 without touching state. Every request
// gives one result, registered in turn by the input register, sample RAM read,
// running sum and result register. Back to back readings of one sensor are handled
// without stalls. No clearing pass is needed after reset: the fill counts keep
// unwritten RAM entries from being used. Limits are written through the config
// port; the user must do so only while the block is idle; it does not check this.
`include "sensor_running_average_alarm_defines.svh"

module sensor_running_average_alarm import sra_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sra_in_if.sink    i_sample,
    sra_out_if.source o_result,
    sra_cfg_if.sink   i_cfg
);

    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic signed [SAMPLE_W-1:0] sample;
    } t_s1;

    typedef struct packed {
        logic                       known;
        logic                       full;
        logic [SLOT_W-1:0]          slot;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] sample;
    } t_s2;

    typedef struct packed {
        logic                    known;
        logic                    full;
        logic [SLOT_W-1:0]       slot;
        logic signed [SUM_W-1:0] sum;
    } t_s3;

    typedef struct packed {
        t_status                 status;
        logic [INDEX_W-1:0]      index;
        logic signed [AVG_W-1:0] avg;
    } t_out;

    logic                       r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_s1                        r_s1;
    t_s2                        r_s2;
    t_s3                        r_s3;
    t_out                       r_out;
    logic                       r_s2_fwd;
    logic signed [SAMPLE_W-1:0] r_s2_fwd_data;

    logic [FILL_W-1:0]          r_fill [SENSOR_COUNT];
    logic [PTR_W-1:0]           r_ptr  [SENSOR_COUNT];
    logic signed [SUM_W-1:0]    r_sum  [SENSOR_COUNT];
    logic signed [TEMP_W-1:0]   r_hot_limit, r_cold_limit;

    logic                       w_adv;
    logic                       w_s1_known;
    logic [SLOT_W-1:0]          w_s1_slot;
    logic                       w_s1_full;
    logic [PTR_W-1:0]           w_s1_ptr;
    logic [PTR_W-1:0]           n_ptr;
    logic [ADDR_W-1:0]          w_s1_addr;
    logic                       w_s1_upd;

    logic [SAMPLE_W-1:0]        w_ram_rdata;
    logic                       w_ram_we;
    logic signed [SAMPLE_W-1:0] w_oldest;
    logic signed [SUM_W-1:0]    w_drop;
    logic signed [SUM_W-1:0]    w_s2_sum;

    logic                       w_s3_neg;
    logic [SUM_W-1:0]           w_s3_mag;
    logic [PROD_W-1:0]          w_s3_prod;
    logic [SUM_W-1:0]           w_s3_quot;
    logic [SUM_W-1:0]           w_s3_avg_wide;
    logic signed [AVG_W-1:0]    w_s3_avg;
    t_status                    w_s3_status;

    // Whole pipe moves when the result register is free or being drained.
    assign w_adv          = !r_out_valid || o_result.ready;
    assign i_sample.ready = w_adv;
    assign i_cfg.ready    = 1'b1;

    // Stage 1: id match, slot state lookup, RAM read address.
    always_comb begin
        w_s1_known = 1'b0;
        w_s1_slot  = '0;
        for (int i = MATCH_COUNT - 1; i >= 0; i--) begin
            if (r_s1.id == KNOWN_IDS[i]) begin
                w_s1_known = 1'b1;
                w_s1_slot  = SLOT_W'(i);
            end
        end
    end

    assign w_s1_full = (r_fill[w_s1_slot] == FILL_W'(WINDOW));
    assign w_s1_ptr  = r_ptr[w_s1_slot];
    assign n_ptr     = (w_s1_ptr == PTR_W'(WINDOW - 1)) ? '0 : w_s1_ptr + 1'b1;
    assign w_s1_addr = ADDR_W'(w_s1_slot) * ADDR_W'(WINDOW) + ADDR_W'(w_s1_ptr);
    assign w_s1_upd  = w_adv && r_s1_valid && w_s1_known;

    sra_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_sample_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_s2.addr),
        .i_wr_data (r_s2.sample),
        .i_rd_en   (w_adv),
        .i_rd_addr (w_s1_addr),
        .o_rd_data (w_ram_rdata)
    );

    // Stage 2: running sum update, sample write-back.
    assign w_ram_we = w_adv && r_s2_valid && r_s2.known;
    assign w_oldest = r_s2_fwd ? r_s2_fwd_data : $signed(w_ram_rdata);
    assign w_drop   = r_s2.full ? SUM_W'(w_oldest) : SUM_W'(0);
    assign w_s2_sum = r_sum[r_s2.slot] + SUM_W'(r_s2.sample) - w_drop;

    // Stage 3: divide by WINDOW toward zero, limit compare.
    assign w_s3_neg      = r_s3.sum[SUM_W-1];
    assign w_s3_mag      = w_s3_neg ? SUM_W'(-r_s3.sum) : SUM_W'(r_s3.sum);
    assign w_s3_prod     = PROD_W'(w_s3_mag) * PROD_W'(RECIP);
    assign w_s3_quot     = w_s3_prod[DIV_SHIFT +: SUM_W];
    assign w_s3_avg_wide = w_s3_neg ? -w_s3_quot : w_s3_quot;
    assign w_s3_avg      = w_s3_avg_wide[AVG_W-1:0];

    always_comb begin
        priority if (!r_s3.known) begin
            w_s3_status = ST_UNKNOWN;
        end else if (!r_s3.full) begin
            w_s3_status = ST_FILLING;
        end else if (w_s3_avg != '0 && w_s3_avg > r_hot_limit) begin
            w_s3_status = ST_TOO_HOT;
        end else if (w_s3_avg != '0 && w_s3_avg < r_cold_limit) begin
            w_s3_status = ST_TOO_COLD;
        end else begin
            w_s3_status = ST_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hot_limit  <= HOT_LIMIT_RST;
            r_cold_limit <= COLD_LIMIT_RST;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_fill[i] <= '0;
                r_ptr[i]  <= '0;
                r_sum[i]  <= '0;
            end
        end else begin
            if (w_adv) begin
                r_s1_valid  <= i_sample.valid;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_out_valid <= r_s3_valid;
            end
            if (w_s1_upd) begin
                if (!w_s1_full) begin
                    r_fill[w_s1_slot] <= r_fill[w_s1_slot] + 1'b1;
                end
                r_ptr[w_s1_slot] <= n_ptr;
            end
            if (w_ram_we) begin
                r_sum[r_s2.slot] <= w_s2_sum;
            end
            if (i_cfg.valid) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    CFG_HOT_LIMIT:  r_hot_limit  <= $signed(i_cfg.data);
                    CFG_COLD_LIMIT: r_cold_limit <= $signed(i_cfg.data);
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1.id       <= i_sample.reading_id;
            r_s1.sample   <= i_sample.sample_value;

            r_s2.known    <= w_s1_known;
            r_s2.full     <= w_s1_full;
            r_s2.slot     <= w_s1_slot;
            r_s2.addr     <= w_s1_addr;
            r_s2.sample   <= r_s1.sample;
            // RAM read and write hit the same entry only when the window is one deep.
            r_s2_fwd      <= w_ram_we && r_s1_valid && w_s1_known && (w_s1_addr == r_s2.addr);
            r_s2_fwd_data <= r_s2.sample;

            r_s3.known    <= r_s2.known;
            r_s3.full     <= r_s2.full;
            r_s3.slot     <= r_s2.slot;
            r_s3.sum      <= w_s2_sum;

            r_out.status  <= w_s3_status;
            r_out.index   <= r_s3.known ? INDEX_W'(r_s3.slot) : '0;
            r_out.avg     <= (r_s3.known && r_s3.full) ? w_s3_avg : '0;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out.status;
    assign o_result.sensor_index = r_out.index;
    assign o_result.average      = r_out.avg;

    `SRA_ASSERT_IMP(a_unknown_clean, i_clk, i_rst_n, o_result.valid && o_result.status == ST_UNKNOWN, o_result.sensor_index == '0 && o_result.average == '0, "unknown id with slot or average")
    `SRA_ASSERT_IMP(a_fill_zero_avg, i_clk, i_rst_n, o_result.valid && o_result.status == ST_FILLING, o_result.average == '0, "filling result carries an average")
    `SRA_ASSERT_IMP(a_fwd_window_one, i_clk, i_rst_n, r_s2_valid && r_s2_fwd, WINDOW == 1, "sample RAM collision")
    `SRA_ASSERT_NXT(a_s3_to_out, i_clk, i_rst_n, r_s3_valid && w_adv, r_out_valid, "stage 3 request lost")

endmodule

// ===== sim/sensor_running_average_alarm_tb.sv =====
// Testbench for sensor_running_average_alarm: directed and random sensor readings,
// limit register writes and back pressure, checked against a running-window predictor.
// Depends on sra_pkg and the sra_*_if interfaces.
module sensor_running_average_alarm_tb import sra_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        t_status                 status;
        logic [INDEX_W-1:0]      sensor_index;
        logic signed [AVG_W-1:0] average;
    } t_alarm_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sra_in_if  reading_if ();
    sra_out_if alarm_if ();
    sra_cfg_if cfg_if ();

    sensor_running_average_alarm u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (reading_if),
        .o_result (alarm_if),
        .i_cfg    (cfg_if)
    );

    // predictor state
    logic signed [SAMPLE_W-1:0] window_samples [SENSOR_COUNT][$];
    int                         window_total   [SENSOR_COUNT] = '{default: 0};
    logic signed [TEMP_W-1:0]   hot_limit;
    logic signed [TEMP_W-1:0]   cold_limit;
    t_alarm_result              expected_alarms [$];

    int error_count    = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_alarm_result predict_alarm(input logic [ID_W-1:0] id,
                                                    input logic signed [SAMPLE_W-1:0] sample);
        t_alarm_result res;
        int            slot;
        int            avg;
        res.status       = ST_UNKNOWN;
        res.sensor_index = '0;
        res.average      = '0;
        slot = -1;
        for (int i = MATCH_COUNT - 1; i >= 0; i--) begin
            if (KNOWN_IDS[i] == id) slot = i;
        end
        if (slot < 0) return res;
        res.sensor_index = INDEX_W'(slot);
        window_samples[slot].push_back(sample);
        window_total[slot] += sample;
        if (window_samples[slot].size() <= WINDOW) begin
            res.status = ST_FILLING;
            return res;
        end
        window_total[slot] -= window_samples[slot].pop_front();
        avg = window_total[slot] / WINDOW;
        res.average = AVG_W'(avg);
        if (avg != 0 && avg > hot_limit) begin
            res.status = ST_TOO_HOT;
        end else if (avg != 0 && avg < cold_limit) begin
            res.status = ST_TOO_COLD;
        end else begin
            res.status = ST_NORMAL;
        end
        return res;
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        if ($urandom_range(99) < 85) return KNOWN_IDS[$urandom_range(MATCH_COUNT - 1)];
        return ID_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] near_limit(
            input logic signed [TEMP_W-1:0] lim);
        int v;
        v = lim + int'($urandom_range(600)) - 300;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) return SAMPLE_W'($urandom);
        if (pick < 55) return near_limit(hot_limit);
        if (pick < 90) return near_limit(cold_limit);
        return SAMPLE_W'(int'($urandom_range(40)) - 20);
    endfunction

    task automatic send_reading(input logic [ID_W-1:0] id,
                                input logic signed [SAMPLE_W-1:0] sample);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            reading_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        reading_if.valid        <= 1'b1;
        reading_if.reading_id   <= id;
        reading_if.sample_value <= sample;
        do @(posedge i_clk); while (!reading_if.ready);
        expected_alarms.push_back(predict_alarm(id, sample));
    endtask

    task automatic wait_for_alarms();
        reading_if.valid <= 1'b0;
        while (expected_alarms.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [TEMP_W-1:0] hot, input logic [TEMP_W-1:0] cold);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_HOT_LIMIT;
        cfg_if.data  <= hot;
        do @(posedge i_clk); while (!cfg_if.ready);
        hot_limit = hot;
        cfg_if.index <= CFG_COLD_LIMIT;
        cfg_if.data  <= cold;
        do @(posedge i_clk); while (!cfg_if.ready);
        cold_limit = cold;
        cfg_if.valid <= 1'b0;
    endtask

    // filling, full-scale windows, zero average and truncation toward zero
    task automatic test_fill_and_extremes();
        repeat (6) send_reading(KNOWN_IDS[0], 16'sd32767);
        repeat (6) send_reading(KNOWN_IDS[1], 16'sh8000);
        repeat (6) send_reading(KNOWN_IDS[2], 16'sd0);
        send_reading(KNOWN_IDS[2], -16'sd3);
    endtask

    task automatic test_unknown_ids();
        send_reading(16'h0000, 16'sh8000);
        send_reading(16'hFFFF, 16'sd32767);
        send_reading(16'd16, -16'sd1);
    endtask

    task automatic test_limit_settings();
        wait_for_alarms();
        // inverted limits: too hot wins
        write_limits(16'(-100), 16'd100);
        send_reading(KNOWN_IDS[2], 16'sd250);
        wait_for_alarms();
        write_limits(16'h7FFF, 16'h8000);
        send_reading(KNOWN_IDS[0], 16'sd32767);
        send_reading(KNOWN_IDS[1], 16'sh8000);
        wait_for_alarms();
        write_limits(16'h8000, 16'h7FFF);
        send_reading(KNOWN_IDS[0], 16'sd32767);
        send_reading(KNOWN_IDS[1], 16'sh8000);
        send_reading(KNOWN_IDS[MATCH_COUNT - 1], 16'sd0);
    endtask

    task automatic test_backpressure();
        wait_for_alarms();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        @(posedge i_clk);
        repeat (40) send_reading(random_id(), random_sample());
        wait_for_alarms();
        repeat (5) send_reading(random_id(), random_sample());
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct,
                                       input logic [TEMP_W-1:0] hot,
                                       input logic [TEMP_W-1:0] cold);
        wait_for_alarms();
        write_limits(hot, cold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_reading(random_id(), random_sample());
    endtask

    // result sink: random stalls, long hold-off, and the scoreboard check
    always @(posedge i_clk) begin : alarm_sink
        t_alarm_result want;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            alarm_if.ready <= 1'b0;
        end else begin
            alarm_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && alarm_if.valid && alarm_if.ready) begin
            if (expected_alarms.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: status %0d index %0d average %0d", $time,
                         alarm_if.status, alarm_if.sensor_index, alarm_if.average);
            end else begin
                want = expected_alarms.pop_front();
                if (alarm_if.status !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             want.status, alarm_if.status);
                end
                if (alarm_if.sensor_index !== want.sensor_index) begin
                    error_count++;
                    $display("%0t: sensor_index mismatch: expected %0d, actual %0d", $time,
                             want.sensor_index, alarm_if.sensor_index);
                end
                if (alarm_if.average !== want.average) begin
                    error_count++;
                    $display("%0t: average mismatch: expected %0d, actual %0d", $time,
                             want.average, alarm_if.average);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sensor_running_average_alarm_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n                 <= 1'b0;
        reading_if.valid        <= 1'b0;
        reading_if.reading_id   <= '0;
        reading_if.sample_value <= '0;
        cfg_if.valid            <= 1'b0;
        cfg_if.index            <= CFG_HOT_LIMIT;
        cfg_if.data             <= '0;
        hot_limit  = HOT_LIMIT_RST;
        cold_limit = COLD_LIMIT_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_and_extremes();
        test_unknown_ids();
        test_limit_settings();
        test_backpressure();
        test_random_traffic(95, 0, 0, HOT_LIMIT_RST, COLD_LIMIT_RST);
        test_random_traffic(95, 49, 0, 16'($urandom_range(12000, 3000)),
                            16'($urandom_range(2999, 0)));
        test_random_traffic(95, 0, 49, 16'($urandom), 16'($urandom));
        test_random_traffic(95, 16, 16, 16'(-int'($urandom_range(1000))),
                            16'(-int'($urandom_range(8000, 1001))));
        wait_for_alarms();

        if (error_count == 0) begin
            $display("sensor_running_average_alarm_tb: clean");
        end else begin
            $display("sensor_running_average_alarm_tb: errors");
        end
        $finish;
    end

endmodule
